// ===== rtl/mbb_pkg.sv =====
`default_nettype none
package mbb_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_RADIUS  = 7;
   localparam int LANES       = 4;
   localparam int MAX_LINES   = 4096;
   localparam int STORE_LINES = 2 * MAX_RADIUS + 1;
   localparam int STORE_DEPTH = STORE_LINES * MAX_WIDTH;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int SLOT_W      = $clog2(STORE_LINES);
   localparam int ROW_W       = $clog2(MAX_LINES);
   localparam int POS_W       = 23;
   localparam int SUM_W       = 16;
   localparam int PIX_W       = 8 * LANES;
   localparam int CSR_W       = 13;

   typedef enum logic [1:0] {
      REG_RADIUS        = 2'd0,
      REG_FRAME_WIDTH   = 2'd1,
      REG_FRAME_HEIGHT  = 2'd2,
      REG_CHANNEL_COUNT = 2'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROW_INIT,
      ST_SUM,
      ST_LAST,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_PUT
   } state_type;

   typedef struct packed {
      logic       start;
      logic [7:0] area;
   } div_ctl_type;

endpackage
`default_nettype wire

// ===== rtl/mbb_channels.sv =====
`default_nettype none
interface mbb_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] sample0;
   logic [7:0] sample1;
   logic [7:0] sample2;
   logic [7:0] sample3;
   modport source (output valid, command, sample0, sample1, sample2, sample3, input ready);
   modport sink (input valid, command, sample0, sample1, sample2, sample3, output ready);
endinterface

interface mbb_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  blurred0;
   logic [7:0]  blurred1;
   logic [7:0]  blurred2;
   logic [7:0]  blurred3;
   logic [9:0]  out_x;
   logic [11:0] out_y;
   logic        frame_done;
   modport source (output valid, blurred0, blurred1, blurred2, blurred3, out_x, out_y,
                   frame_done, input ready);
   modport sink (input valid, blurred0, blurred1, blurred2, blurred3, out_x, out_y,
                 frame_done, output ready);
endinterface
`default_nettype wire

// ===== rtl/multichannel_box_blur_top.sv =====
`default_nettype none
// multichannel box blur, clamp-to-edge borders
// req_chan carries one transaction per pixel in raster order (command 0) or a
// drain step (command 1); rsp_chan carries the blurred pixel with its position
// and a frame_done flag on the last pixel of the frame
// csr_we/csr_index/csr_wdata write radius, frame width, frame height and
// channel count; any write restarts the frame
// the first result leaves after r*W + r + 1 pixels; once the frame is in, each
// drain transaction pushes out one more result
// a pixel that yields a result holds the block for one row-store read per window
// sample on the single read port and then for a run of the shared radix-2
// divider; a transaction with no result does not hold the block
// a new transaction is taken while a finished result waits in the output
// register; a stalled receiver only blocks once the next result is ready
// reset: synchronous, returns registers to radius 1, 1024x1024, 4 channels and
// restarts the frame; the row store is not cleared, a window only reads lines
// of the current frame
module multichannel_box_blur_top (
   input  wire logic                     clock,
   input  wire logic                     reset,
   mbb_req_if.sink                       req_chan,
   mbb_rsp_if.source                     rsp_chan,
   input  wire logic                     csr_we,
   input  wire logic [1:0]               csr_index,
   input  wire logic [mbb_pkg::CSR_W-1:0] csr_wdata
);
   localparam int SW = 14;

   // configuration
   logic [2:0]  radius_ff;
   logic [10:0] width_ff;
   logic [12:0] height_ff;
   logic [2:0]  chans_ff;

   // effective settings
   logic [2:0]  r_eff;
   logic [3:0]  k_eff;
   logic [10:0] w_eff;
   logic [12:0] h_eff;
   logic [2:0]  c_eff;
   logic [23:0] total;
   logic [13:0] delay;
   logic [7:0]  area;

   // positions
   logic [mbb_pkg::POS_W-1:0]  in_pos_ff, out_pos_ff;
   logic [mbb_pkg::COL_W-1:0]  in_x_ff, out_x_ff;
   logic [mbb_pkg::ROW_W-1:0]  out_y_ff;
   logic [mbb_pkg::SLOT_W-1:0] in_slot_ff, out_slot_ff;

   // window walk
   mbb_pkg::state_type         state_ff, state_in;
   logic [3:0]                 dx_ff, dy_ff;
   logic [mbb_pkg::ROW_W-1:0]  row_ff;
   logic [mbb_pkg::SLOT_W-1:0] slot_ff;
   logic                       rd_valid_ff;
   logic [mbb_pkg::SUM_W-1:0]  acc_ff [mbb_pkg::LANES];

   // output register
   logic        rsp_valid_ff;
   logic [7:0]  blur_ff [mbb_pkg::LANES];
   logic [9:0]  ox_ff;
   logic [11:0] oy_ff;
   logic        done_ff;

   logic                       accept, in_open, out_open, emit_start, out_free, last_out;
   logic                       wr_en, rd_en, load_out;
   logic [mbb_pkg::ADDR_W-1:0] rd_addr;
   logic [mbb_pkg::PIX_W-1:0]  rd_data;
   logic signed [SW-1:0]       col_s, row0_s, rown_s;
   logic [mbb_pkg::COL_W-1:0]  col;
   logic [mbb_pkg::ROW_W-1:0]  row0, rown;
   logic [3:0]                 back;
   logic [mbb_pkg::SLOT_W-1:0] slot0;
   logic                       row_end, win_end;
   mbb_pkg::div_ctl_type       div_ctl;
   logic [7:0]                 quot [mbb_pkg::LANES];
   logic                       div_done;

   // clamp the registers into legal range
   always_comb begin
      r_eff = (radius_ff == 3'd0) ? 3'd1 : radius_ff;
      k_eff = {r_eff, 1'b1};
      if (width_ff < {7'd0, k_eff}) w_eff = {7'd0, k_eff};
      else if (width_ff > 11'(mbb_pkg::MAX_WIDTH)) w_eff = 11'(mbb_pkg::MAX_WIDTH);
      else w_eff = width_ff;
      if (height_ff == 13'd0) h_eff = 13'd1;
      else if (height_ff > 13'(mbb_pkg::MAX_LINES)) h_eff = 13'(mbb_pkg::MAX_LINES);
      else h_eff = height_ff;
      if (chans_ff == 3'd0) c_eff = 3'd1;
      else if (chans_ff > 3'(mbb_pkg::LANES)) c_eff = 3'(mbb_pkg::LANES);
      else c_eff = chans_ff;
   end

   assign total = 24'(w_eff) * 24'(h_eff);
   assign delay = 14'(r_eff) * 14'(w_eff) + 14'(r_eff);
   assign area  = 8'(k_eff) * 8'(k_eff);

   assign accept     = req_chan.valid && req_chan.ready;
   assign in_open    = 24'(in_pos_ff) < total;
   assign out_open   = 24'(out_pos_ff) < total;
   assign emit_start = in_open ? (!req_chan.command &&
                                  (in_pos_ff - out_pos_ff) == mbb_pkg::POS_W'(delay))
                               : out_open;
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign last_out   = 24'(out_pos_ff) + 24'd1 >= total;
   assign wr_en      = accept && in_open && !req_chan.command;

   // window column, clamped to the line
   always_comb begin
      col_s = $signed(SW'(out_x_ff)) - $signed(SW'(r_eff)) + $signed(SW'(dx_ff));
      if (col_s < 0) col = '0;
      else if (col_s > $signed(SW'(w_eff) - SW'(1))) col = mbb_pkg::COL_W'(w_eff - 11'd1);
      else col = col_s[mbb_pkg::COL_W-1:0];
   end

   // first window line and its slot in the row store
   always_comb begin
      row0_s = $signed(SW'(out_y_ff)) - $signed(SW'(r_eff));
      row0   = (row0_s < 0) ? '0 : row0_s[mbb_pkg::ROW_W-1:0];
      back   = 4'(out_y_ff - row0);
      if ({1'b0, out_slot_ff} >= {1'b0, back}) slot0 = mbb_pkg::SLOT_W'(out_slot_ff - back);
      else slot0 = mbb_pkg::SLOT_W'(5'(out_slot_ff) + 5'(mbb_pkg::STORE_LINES) - 5'(back));
   end

   // next window line, clamped to the frame
   always_comb begin
      rown_s = row0_s + $signed(SW'(dy_ff)) + $signed(SW'(1));
      if (rown_s < 0) rown = '0;
      else if (rown_s > $signed(SW'(h_eff) - SW'(1))) rown = mbb_pkg::ROW_W'(h_eff - 13'd1);
      else rown = rown_s[mbb_pkg::ROW_W-1:0];
   end

   assign row_end = dx_ff == (k_eff - 4'd1);
   assign win_end = row_end && dy_ff == (k_eff - 4'd1);
   assign rd_addr = mbb_pkg::ADDR_W'(slot_ff) * mbb_pkg::ADDR_W'(mbb_pkg::MAX_WIDTH)
                    + mbb_pkg::ADDR_W'(col);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mbb_pkg::ST_IDLE:     if (accept && emit_start) state_in = mbb_pkg::ST_ROW_INIT;
         mbb_pkg::ST_ROW_INIT: state_in = mbb_pkg::ST_SUM;
         mbb_pkg::ST_SUM:      if (win_end) state_in = mbb_pkg::ST_LAST;
         mbb_pkg::ST_LAST:     state_in = mbb_pkg::ST_DIV_GO;
         mbb_pkg::ST_DIV_GO:   state_in = mbb_pkg::ST_DIV_WAIT;
         mbb_pkg::ST_DIV_WAIT: if (div_done) state_in = mbb_pkg::ST_PUT;
         mbb_pkg::ST_PUT:      if (out_free) state_in = mbb_pkg::ST_IDLE;
         default:              state_in = mbb_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_chan.ready = state_ff == mbb_pkg::ST_IDLE;
      rd_en          = state_ff == mbb_pkg::ST_SUM;
      div_ctl.start  = state_ff == mbb_pkg::ST_DIV_GO;
      div_ctl.area   = area;
      load_out       = (state_ff == mbb_pkg::ST_PUT) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mbb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // configuration and positions
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff   <= 3'd1;
         width_ff    <= 11'd1024;
         height_ff   <= 13'd1024;
         chans_ff    <= 3'd4;
         in_pos_ff   <= '0;
         out_pos_ff  <= '0;
         in_x_ff     <= '0;
         in_slot_ff  <= '0;
         out_x_ff    <= '0;
         out_y_ff    <= '0;
         out_slot_ff <= '0;
      end else if (csr_we) begin
         unique case (mbb_pkg::reg_index_type'(csr_index))
            mbb_pkg::REG_RADIUS:        radius_ff <= csr_wdata[2:0];
            mbb_pkg::REG_FRAME_WIDTH:   width_ff  <= csr_wdata[10:0];
            mbb_pkg::REG_FRAME_HEIGHT:  height_ff <= csr_wdata[12:0];
            mbb_pkg::REG_CHANNEL_COUNT: chans_ff  <= csr_wdata[2:0];
            default:                    chans_ff  <= chans_ff;
         endcase
         in_pos_ff   <= '0;
         out_pos_ff  <= '0;
         in_x_ff     <= '0;
         in_slot_ff  <= '0;
         out_x_ff    <= '0;
         out_y_ff    <= '0;
         out_slot_ff <= '0;
      end else if (load_out && last_out) begin
         // frame finished, start over
         in_pos_ff   <= '0;
         out_pos_ff  <= '0;
         in_x_ff     <= '0;
         in_slot_ff  <= '0;
         out_x_ff    <= '0;
         out_y_ff    <= '0;
         out_slot_ff <= '0;
      end else if (load_out) begin
         out_pos_ff <= out_pos_ff + 1'b1;
         if (11'(out_x_ff) == w_eff - 11'd1) begin
            out_x_ff    <= '0;
            out_y_ff    <= out_y_ff + 1'b1;
            out_slot_ff <= (out_slot_ff == mbb_pkg::SLOT_W'(mbb_pkg::STORE_LINES - 1))
                           ? '0 : out_slot_ff + 1'b1;
         end else begin
            out_x_ff <= out_x_ff + 1'b1;
         end
      end else if (wr_en) begin
         in_pos_ff <= in_pos_ff + 1'b1;
         if (11'(in_x_ff) == w_eff - 11'd1) begin
            in_x_ff    <= '0;
            in_slot_ff <= (in_slot_ff == mbb_pkg::SLOT_W'(mbb_pkg::STORE_LINES - 1))
                          ? '0 : in_slot_ff + 1'b1;
         end else begin
            in_x_ff <= in_x_ff + 1'b1;
         end
      end else if (accept && !in_open && !out_open) begin
         // stray transaction after a finished frame
         in_pos_ff   <= '0;
         out_pos_ff  <= '0;
         in_x_ff     <= '0;
         in_slot_ff  <= '0;
         out_x_ff    <= '0;
         out_y_ff    <= '0;
         out_slot_ff <= '0;
      end
   end

   // window walk and accumulation
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= rd_en;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == mbb_pkg::ST_ROW_INIT) begin
         dx_ff   <= '0;
         dy_ff   <= '0;
         row_ff  <= row0;
         slot_ff <= slot0;
         for (int i = 0; i < mbb_pkg::LANES; i++) begin
            acc_ff[i] <= '0;
         end
      end else begin
         if (state_ff == mbb_pkg::ST_SUM) begin
            if (row_end) begin
               dx_ff <= '0;
               dy_ff <= dy_ff + 1'b1;
               if (rown != row_ff) begin
                  row_ff  <= rown;
                  slot_ff <= (slot_ff == mbb_pkg::SLOT_W'(mbb_pkg::STORE_LINES - 1))
                             ? '0 : slot_ff + 1'b1;
               end
            end else begin
               dx_ff <= dx_ff + 1'b1;
            end
         end
         if (rd_valid_ff) begin
            for (int i = 0; i < mbb_pkg::LANES; i++) begin
               acc_ff[i] <= acc_ff[i] + mbb_pkg::SUM_W'(rd_data[8*i +: 8]);
            end
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         for (int i = 0; i < mbb_pkg::LANES; i++) begin
            blur_ff[i] <= (3'(i) < c_eff) ? quot[i] : 8'd0;
         end
         ox_ff   <= out_x_ff;
         oy_ff   <= out_y_ff;
         done_ff <= last_out;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.blurred0   = blur_ff[0];
   assign rsp_chan.blurred1   = blur_ff[1];
   assign rsp_chan.blurred2   = blur_ff[2];
   assign rsp_chan.blurred3   = blur_ff[3];
   assign rsp_chan.out_x      = ox_ff;
   assign rsp_chan.out_y      = oy_ff;
   assign rsp_chan.frame_done = done_ff;

   mbb_row_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (mbb_pkg::ADDR_W'(in_slot_ff) * mbb_pkg::ADDR_W'(mbb_pkg::MAX_WIDTH)
                + mbb_pkg::ADDR_W'(in_x_ff)),
      .wr_data ({req_chan.sample3, req_chan.sample2, req_chan.sample1, req_chan.sample0}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mbb_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (acc_ff),
      .quotient (quot),
      .done     (div_done)
   );
endmodule
`default_nettype wire

// ===== rtl/mbb_row_store.sv =====
`default_nettype none
module mbb_row_store (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [mbb_pkg::ADDR_W-1:0] wr_addr,
   input  wire logic [mbb_pkg::PIX_W-1:0]  wr_data,
   input  wire logic                      rd_en,
   input  wire logic [mbb_pkg::ADDR_W-1:0] rd_addr,
   output logic      [mbb_pkg::PIX_W-1:0]  rd_data
);
   logic [mbb_pkg::PIX_W-1:0] mem [mbb_pkg::STORE_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

// ===== rtl/mbb_divider.sv =====
`default_nettype none
module mbb_divider (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire mbb_pkg::div_ctl_type     ctl,
   input  wire logic [mbb_pkg::SUM_W-1:0] dividend [mbb_pkg::LANES],
   output logic      [7:0]               quotient [mbb_pkg::LANES],
   output logic                          done
);
   localparam int CNT_W = $clog2(mbb_pkg::SUM_W + 1);

   logic [mbb_pkg::SUM_W-1:0] dvd_ff [mbb_pkg::LANES];
   logic [mbb_pkg::SUM_W-1:0] dvd_in [mbb_pkg::LANES];
   logic [7:0]                rem_ff [mbb_pkg::LANES];
   logic [7:0]                rem_in [mbb_pkg::LANES];
   logic [7:0]                area_ff;
   logic [CNT_W-1:0]          cnt_ff;
   logic                      busy_ff;

   // one restoring step per cycle on every lane
   always_comb begin
      logic [8:0] trial;
      for (int i = 0; i < mbb_pkg::LANES; i++) begin
         trial = {rem_ff[i], dvd_ff[i][mbb_pkg::SUM_W-1]};
         if (trial >= {1'b0, area_ff}) begin
            rem_in[i] = 8'(trial - {1'b0, area_ff});
            dvd_in[i] = {dvd_ff[i][mbb_pkg::SUM_W-2:0], 1'b1};
         end else begin
            rem_in[i] = trial[7:0];
            dvd_in[i] = {dvd_ff[i][mbb_pkg::SUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (ctl.start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNT_W'(mbb_pkg::SUM_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         area_ff <= ctl.area;
         for (int i = 0; i < mbb_pkg::LANES; i++) begin
            dvd_ff[i] <= dividend[i];
            rem_ff[i] <= '0;
         end
      end else if (busy_ff) begin
         for (int i = 0; i < mbb_pkg::LANES; i++) begin
            dvd_ff[i] <= dvd_in[i];
            rem_ff[i] <= rem_in[i];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < mbb_pkg::LANES; i++) begin
         quotient[i] = dvd_ff[i][7:0];
      end
   end

   assign done = !busy_ff && !ctl.start;
endmodule
`default_nettype wire
